/* rtl/core/qbr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbr_pkg
// Shared types and constants of the four-channel bridge converter reader.
// ----------------------------------------------------------------------------
package qbr_pkg;

  localparam int unsigned LINE_W   = 4;   // data lines carried by one request
  localparam int unsigned VAL_W    = 24;  // width of a reported reading
  localparam int unsigned NUM_OUT  = 4;   // reading ports on the top level
  localparam int unsigned GAIN_W   = 2;
  localparam int unsigned GAIN_MAX = 3;
  localparam int unsigned CFG_IDX_W = 2;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_PULSES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLEEP       = 2'd1;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 2'd1;

  // Per-request command from the sequencer to every cell
  typedef struct packed {
    logic clear;     // start of a read: zero the shift register
    logic shift_en;  // clock-low tick of a data bit: shift in the line
    logic latch;     // last tick: capture the sign-extended sample
  } cell_ctl_t;

  // One result as held in the output stage
  typedef struct packed {
    logic                    clock_level;
    logic                    busy_res;
    logic                    ready_res;
    logic                    done_res;
    logic signed [VAL_W-1:0] value_zero;
    logic signed [VAL_W-1:0] value_one;
    logic signed [VAL_W-1:0] value_two;
    logic signed [VAL_W-1:0] value_three;
  } result_t;

endpackage

/* rtl/core/qbr_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbr_cell
// One channel: shift register and held reading; passes the remaining data
// lines on to the next cell.
// ----------------------------------------------------------------------------
module qbr_cell
  import qbr_pkg::*;
#(
  parameter int unsigned DATA_BITS = 24
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cell_ctl_t               ctl_i,
  input  logic [LINE_W-1:0]       lines_i,
  output logic [LINE_W-1:0]       lines_o,
  output logic signed [VAL_W-1:0] held_o
);

  logic [DATA_BITS-1:0]    shift_q, shift_d;
  logic signed [VAL_W-1:0] held_q, held_d;

  // take the top line, hand the rest down the row
  assign lines_o = {lines_i[LINE_W-2:0], 1'b0};

  always_comb begin
    shift_d = shift_q;
    if (ctl_i.clear) begin
      shift_d = '0;
    end else if (ctl_i.shift_en) begin
      shift_d = {shift_q[DATA_BITS-2:0], lines_i[LINE_W-1]};
    end
    held_d = held_q;
    if (ctl_i.latch) begin
      held_d = VAL_W'($signed(shift_d));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= '0;
      held_q  <= '0;
    end else begin
      shift_q <= shift_d;
      held_q  <= held_d;
    end
  end

  assign held_o = held_d;

endmodule

/* rtl/core/qbr_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbr_ctrl
// Tick sequencer: start detection, bit and gain pulse counting, clock level.
// ----------------------------------------------------------------------------
module qbr_ctrl
  import qbr_pkg::*;
#(
  parameter int unsigned DATA_BITS = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic              start_req_i,
  input  logic              lines_low_i,
  input  logic              sleep_i,
  input  logic [GAIN_W-1:0] gain_pulses_i,
  output cell_ctl_t         ctl_o,
  output logic              clock_level_o,
  output logic              busy_o
);

  localparam int unsigned TICK_W = $clog2(2 * (DATA_BITS + GAIN_MAX));
  localparam int unsigned CMP_W  = TICK_W + 1;
  localparam logic [CMP_W-1:0] DATA_PULSES = CMP_W'(DATA_BITS);

  logic [TICK_W-1:0] tick_q, tick_d, tick_cur;
  logic              prog_q, prog_d;
  logic              start_now, active, odd, done;
  logic [CMP_W-1:0]  pulse;

  always_comb begin
    start_now = !prog_q && start_req_i && lines_low_i && !sleep_i;
    active    = prog_q || start_now;
    tick_cur  = start_now ? '0 : tick_q;
    odd       = tick_cur[0];
    pulse     = CMP_W'(tick_cur >> 1);
    done      = active && odd &&
                ((pulse + CMP_W'(1)) >= (DATA_PULSES + CMP_W'(gain_pulses_i)));

    ctl_o.clear    = accept_i && start_now;
    ctl_o.shift_en = accept_i && active && odd && (pulse < DATA_PULSES);
    ctl_o.latch    = accept_i && done;

    clock_level_o = active ? !odd : sleep_i;
    busy_o        = active;

    prog_d = prog_q;
    tick_d = tick_q;
    if (accept_i && active) begin
      prog_d = !done;
      tick_d = done ? '0 : tick_cur + TICK_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_q <= 1'b0;
      tick_q <= '0;
    end else begin
      prog_q <= prog_d;
      tick_q <= tick_d;
    end
  end

endmodule

/* rtl/core/qbr_skid.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbr_skid
// Output register with a skid stage, so a request is taken while a result
// waits.
// ----------------------------------------------------------------------------
module qbr_skid
  import qbr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t data_i,
  output logic    full_o,
  output logic    valid_o,
  input  logic    stall_i,
  output result_t data_o
);

  logic    main_v_q, skid_v_q;
  result_t main_q, skid_q;
  logic    pop;

  assign pop     = main_v_q && !stall_i;
  assign full_o  = skid_v_q;
  assign valid_o = main_v_q;
  assign data_o  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (pop) begin
        skid_v_q <= 1'b0;
      end
    end else if (push_i) begin
      if (main_v_q && !pop) begin
        skid_v_q <= 1'b1;
      end else begin
        main_v_q <= 1'b1;
      end
    end else if (pop) begin
      main_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (pop) begin
        main_q <= skid_q;
      end
    end else if (push_i) begin
      if (main_v_q && !pop) begin
        skid_q <= data_i;
      end else begin
        main_q <= data_i;
      end
    end
  end

endmodule

/* rtl/core/quad_bridge_adc_serial_reader.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_bridge_adc_serial_reader
// Serial reader for up to four bridge converters sharing one serial clock.
// ----------------------------------------------------------------------------
// Each request is one tick of the serial interface and yields exactly one
// result, one request per clock cycle while results are taken: the
// sequencer and the channel cells finish a tick combinationally, and a
// two-deep output stage (register plus skid) lets requests flow on.
// A read starts on a tick with start_req set, the block idle, all data lines
// low and power-down clear. Every bit spends a clock-high tick and then a
// clock-low tick on which the lines are sampled, most significant bit first;
// after the data bits the gain pulses follow (1: gain 128, 2: gain 32,
// 3: gain 64) and the final tick reports the sign-extended readings with
// done_res set. A full read takes 2 * (DATA_BITS + gain_pulses) ticks.
// With the sleep register set the idle clock is held high. Write
// configuration only while no results are outstanding; a gain write of zero
// is ignored.
// ----------------------------------------------------------------------------
module quad_bridge_adc_serial_reader
  import qbr_pkg::*;
#(
  parameter int unsigned CHANNELS  = 4,
  parameter int unsigned DATA_BITS = 24
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // request channel
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [LINE_W-1:0]       data_lines_i,
  input  logic                    start_req_i,
  // result channel
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    clock_level_o,
  output logic                    busy_res_o,
  output logic                    ready_res_o,
  output logic                    done_res_o,
  output logic signed [VAL_W-1:0] value_zero_o,
  output logic signed [VAL_W-1:0] value_one_o,
  output logic signed [VAL_W-1:0] value_two_o,
  output logic signed [VAL_W-1:0] value_three_o,
  // configuration channel
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [GAIN_W-1:0]       cfg_data_i
);

  logic              accept;
  logic [GAIN_W-1:0] gain_q;
  logic              pdown_q;
  logic              lines_low;
  cell_ctl_t         ctl;
  logic              clock_level, busy;
  result_t           res;

  logic [LINE_W-1:0]       lines_chain [CHANNELS+1];
  logic signed [VAL_W-1:0] held       [CHANNELS];
  logic signed [VAL_W-1:0] values     [NUM_OUT];

  assign accept    = in_valid_i && !in_stall_o;
  assign lines_low = (data_lines_i == '0);

  // Configuration: always ready; drop a zero gain write
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= GAIN_RESET;
      pdown_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_GAIN_PULSES: begin
          if (cfg_data_i != '0) begin
            gain_q <= cfg_data_i;
          end
        end
        REG_SLEEP: begin
          pdown_q <= cfg_data_i[0];
        end
        default: begin
        end
      endcase
    end
  end

  // Tick sequencer: one command per request, broadcast to the cells
  qbr_ctrl #(
    .DATA_BITS (DATA_BITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .start_req_i   (start_req_i),
    .lines_low_i   (lines_low),
    .sleep_i       (pdown_q),
    .gain_pulses_i (gain_q),
    .ctl_o         (ctl),
    .clock_level_o (clock_level),
    .busy_o        (busy)
  );

  // Row of channel cells; each takes its line off the top of the vector and
  // hands the rest on, so channels past the fourth read zero
  assign lines_chain[0] = data_lines_i;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_cell
    qbr_cell #(
      .DATA_BITS (DATA_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .lines_i (lines_chain[c]),
      .lines_o (lines_chain[c+1]),
      .held_o  (held[c])
    );
  end

  // Report zero on reading ports with no channel behind them
  for (genvar c = 0; c < NUM_OUT; c++) begin : g_val
    if (c < CHANNELS) begin : g_used
      assign values[c] = held[c];
    end else begin : g_unused
      assign values[c] = '0;
    end
  end

  always_comb begin
    res.clock_level = clock_level;
    res.busy_res    = busy;
    res.ready_res   = lines_low;
    res.done_res    = ctl.latch;
    res.value_zero  = values[0];
    res.value_one   = values[1];
    res.value_two   = values[2];
    res.value_three = values[3];
  end

  // Output register and skid stage
  result_t out_res;

  qbr_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (res),
    .full_o  (in_stall_o),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_res)
  );

  assign clock_level_o = out_res.clock_level;
  assign busy_res_o    = out_res.busy_res;
  assign ready_res_o   = out_res.ready_res;
  assign done_res_o    = out_res.done_res;
  assign value_zero_o  = out_res.value_zero;
  assign value_one_o   = out_res.value_one;
  assign value_two_o   = out_res.value_two;
  assign value_three_o = out_res.value_three;

endmodule

/* rtl/core/qbr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbr_checker
// Port-level checks of the reader, bound to the top level.
// ----------------------------------------------------------------------------
module qbr_checker
  import qbr_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic clock_level_o,
  input logic busy_res_o,
  input logic done_res_o
);

  // a completing tick belongs to a read
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> busy_res_o)
    else $error("done reported outside a read");

  // a read completes on a clock-low tick
  a_done_clk_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !clock_level_o)
    else $error("done reported with the clock high");

  // request side only stalls while a result is waiting
  a_stall_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i || out_valid_o)
    else $error("request stalled with no result pending");

  // a stalled result stays offered
  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

endmodule

bind quad_bridge_adc_serial_reader qbr_checker u_qbr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .clock_level_o (clock_level_o),
  .busy_res_o    (busy_res_o),
  .done_res_o    (done_res_o)
);
